/* design/text_console_writer_top_defines.svh */
// Assertion macros shared by the text console writer checkers.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TCW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text console writer check failed");

// next-cycle implication, quiet during reset
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("text console writer check failed");

`endif

/* design/tcw_pkg.sv */
// Shared types, constants and the colour letter decoder of the text console writer.
// No dependencies.
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLS   = 80;
    localparam int DEF_ROWS   = 25;
    localparam int POS_W      = 11;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int TAB_STEP   = 8;

    localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'h9;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_BG = 1'b1;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] char_code;
        logic       message_start;
        logic       escapes_on;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0] cursor_index;
        logic             cell_written;
        logic [POS_W-1:0] cell_addr;
        logic [15:0]      cell_value;
        logic             scrolled;
    } t_out_word;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic scroll_go;
    } t_ctl_cmd;

    typedef struct packed {
        logic scroll;
    } t_dp_stat;

    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] color;
    } t_color_lu;

    function automatic t_color_lu color_of(input logic [7:0] ch);
        t_color_lu r;
        r.hit = 1'b1;
        unique case (ch)
            8'h64: r.color = 4'd0;   // d
            8'h62: r.color = 4'd1;   // b
            8'h67: r.color = 4'd2;   // g
            8'h63: r.color = 4'd3;   // c
            8'h72: r.color = 4'd4;   // r
            8'h6D: r.color = 4'd5;   // m
            8'h59: r.color = 4'd6;   // Y
            8'h57: r.color = 4'd7;   // W
            8'h44: r.color = 4'd8;   // D
            8'h42: r.color = 4'd9;   // B
            8'h47: r.color = 4'd10;  // G
            8'h43: r.color = 4'd11;  // C
            8'h52: r.color = 4'd12;  // R
            8'h4D: r.color = 4'd13;  // M
            8'h79: r.color = 4'd14;  // y
            8'h77: r.color = 4'd15;  // w
            default: begin
                r.hit   = 1'b0;
                r.color = 4'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/tcw_ctrl.sv */
// Sequencer of the text console writer: input capture, commit, scroll and clear waits.
// Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire tcw_pkg::t_dp_stat i_stat,
    input  wire logic              i_scr_busy,
    output tcw_pkg::t_ctl_cmd      o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {S_INIT, S_IDLE, S_EXEC, S_SCROLL} t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit    = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        o_cmd.scroll_go = o_cmd.commit && i_stat.scroll;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_INIT:   if (!i_scr_busy) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_out_valid = 1'b1;
                    n_state     = i_stat.scroll ? S_SCROLL : S_IDLE;
                end
            end
            S_SCROLL: if (!i_scr_busy) n_state = S_IDLE;
            default:  n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/tcw_screen.sv */
// Screen cell store with the clear sweep after reset and the one-row scroll sweep.
// Depends on tcw_pkg.
`default_nettype none

module tcw_screen #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_ROWS,
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
    localparam int AW    = $clog2(CELLS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_scroll_go,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [15:0]   i_wr_data,
    input  wire logic [7:0]    i_attr,
    output logic               o_busy
);
    import tcw_pkg::*;

    localparam int MOVE_CNT = CELLS - SCREEN_COLS;

    logic [15:0]   mem [CELLS];
    logic          r_active;
    logic          r_copy;
    logic [AW-1:0] r_idx;
    logic          r_p_valid;
    logic          r_p_copy;
    logic [AW-1:0] r_p_addr;
    logic [15:0]   r_rd_data;
    logic          idx_moves;
    logic [AW-1:0] rd_addr;

    assign idx_moves = r_copy && (r_idx < AW'(MOVE_CNT));
    assign rd_addr   = idx_moves ? (r_idx + AW'(SCREEN_COLS)) : '0;

    // sweep: one cell per cycle, each copy write lands in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b1;
            r_copy    <= 1'b0;
            r_idx     <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_active;
            if (r_active) begin
                if (r_idx == AW'(CELLS - 1)) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_scroll_go) begin
                r_active <= 1'b1;
                r_copy   <= 1'b1;
                r_idx    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr  <= r_idx;
        r_p_copy  <= idx_moves;
        r_rd_data <= mem[rd_addr];
        if (r_p_valid) begin
            mem[r_p_addr] <= r_p_copy ? r_rd_data : {i_attr, CH_NUL};
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_busy = r_active || r_p_valid;

endmodule

`default_nettype wire

/* design/tcw_datapath.sv */
// Cursor, colour and escape registers, step logic and result register.
// Depends on tcw_pkg.
`default_nettype none

module tcw_datapath #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_ROWS,
    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS,
    localparam int AW    = $clog2(CELLS)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tcw_pkg::t_in_word                   i_in_word,
    input  wire tcw_pkg::t_ctl_cmd                   i_cmd,
    input  wire logic                                i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output tcw_pkg::t_dp_stat                        o_stat,
    output tcw_pkg::t_out_word                       o_out_word,
    output logic                                     o_wr_en,
    output logic [AW-1:0]                            o_wr_addr,
    output logic [15:0]                              o_wr_data,
    output logic [7:0]                               o_attr
);
    import tcw_pkg::*;

    localparam int CW  = $clog2(SCREEN_COLS);
    localparam int CTW = $clog2(SCREEN_COLS + TAB_STEP);
    localparam int RW  = $clog2(SCREEN_ROWS);
    localparam int RTW = $clog2(SCREEN_ROWS + 1);

    t_in_word           r_in;
    t_out_word          r_out;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [COLOR_W-1:0] r_cur_fg, r_cur_bg, r_sav_fg, r_sav_bg;
    logic [COLOR_W-1:0] n_cur_fg, n_cur_bg, sav_fg, sav_bg;
    logic               r_pend_bg, r_pend_fg, n_pend_bg, n_pend_fg;

    t_color_lu          lu;
    logic [7:0]         ch;
    logic               pend_bg, pend_fg, do_put, wr, scroll;
    logic [CTW-1:0]     col_t;
    logic [RTW-1:0]     row_t;
    logic [AW-1:0]      addr, pos;
    logic [AW+POS_W-1:0] addr_x, pos_x;
    logic [15:0]        value;

    always_comb begin
        ch      = r_in.char_code;
        lu      = color_of(ch);
        pend_bg = r_pend_bg && !r_in.message_start;
        pend_fg = r_pend_fg && !r_in.message_start;
        sav_fg  = r_in.message_start ? r_cur_fg : r_sav_fg;
        sav_bg  = r_in.message_start ? r_cur_bg : r_sav_bg;

        n_cur_fg  = r_cur_fg;
        n_cur_bg  = r_cur_bg;
        n_pend_bg = 1'b0;
        n_pend_fg = 1'b0;
        do_put    = 1'b0;
        if (!r_in.escapes_on) begin
            do_put = 1'b1;
        end else if (pend_bg || pend_fg) begin
            if (lu.hit) begin
                if (pend_bg) n_cur_bg = lu.color;
                else         n_cur_fg = lu.color;
            end else if (ch == CH_LX || ch == CH_UX) begin
                if (pend_bg) n_cur_bg = sav_bg;
                else         n_cur_fg = sav_fg;
            end else begin
                do_put = 1'b1;
            end
        end else if (ch == CH_CARET) begin
            n_pend_bg = 1'b1;
        end else if (ch == CH_AMP) begin
            n_pend_fg = 1'b1;
        end else begin
            do_put = 1'b1;
        end

        col_t = CTW'(r_col);
        row_t = RTW'(r_row);
        wr    = 1'b0;
        if (do_put) begin
            case (ch)
                CH_BS:  if (r_col != '0) col_t = CTW'(r_col) - 1'b1;
                CH_TAB: col_t = CTW'(r_col) + CTW'(TAB_STEP);
                CH_CR:  col_t = '0;
                CH_LF: begin
                    col_t = '0;
                    row_t = RTW'(r_row) + 1'b1;
                end
                default: begin
                    if (ch >= CH_SPACE) begin
                        wr    = 1'b1;
                        col_t = CTW'(r_col) + 1'b1;
                    end
                end
            endcase
        end
        if (col_t >= CTW'(SCREEN_COLS)) begin
            col_t = '0;
            row_t = row_t + 1'b1;
        end
        scroll = (row_t >= RTW'(SCREEN_ROWS));
        n_col  = col_t[CW-1:0];
        n_row  = scroll ? RW'(SCREEN_ROWS - 1) : row_t[RW-1:0];

        addr   = AW'(SCREEN_COLS) * AW'(r_row) + AW'(r_col);
        pos    = AW'(SCREEN_COLS) * AW'(n_row) + AW'(n_col);
        addr_x = {{POS_W{1'b0}}, addr};
        pos_x  = {{POS_W{1'b0}}, pos};
        value  = {r_cur_bg, r_cur_fg, ch};
    end

    assign o_stat.scroll = scroll;
    assign o_wr_en       = i_cmd.commit && wr;
    assign o_wr_addr     = addr;
    assign o_wr_data     = value;
    assign o_attr        = {r_cur_bg, r_cur_fg};
    assign o_out_word    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cur_fg  <= RESET_FG;
            r_cur_bg  <= RESET_BG;
            r_sav_fg  <= RESET_FG;
            r_sav_bg  <= RESET_BG;
            r_pend_bg <= 1'b0;
            r_pend_fg <= 1'b0;
        end else if (i_cmd.commit) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_cur_fg  <= n_cur_fg;
            r_cur_bg  <= n_cur_bg;
            r_sav_fg  <= sav_fg;
            r_sav_bg  <= sav_bg;
            r_pend_bg <= n_pend_bg;
            r_pend_fg <= n_pend_fg;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESET_FG: begin
                    r_cur_fg <= i_cfg_data;
                    r_sav_fg <= i_cfg_data;
                end
                CFG_RESET_BG: begin
                    r_cur_bg <= i_cfg_data;
                    r_sav_bg <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_out.cursor_index <= pos_x[POS_W-1:0];
            r_out.cell_written <= wr;
            r_out.cell_addr    <= wr ? addr_x[POS_W-1:0] : '0;
            r_out.cell_value   <= wr ? value : '0;
            r_out.scrolled     <= scroll;
        end
    end

endmodule

`default_nettype wire

/* design/text_console_writer_top.sv */
// Top level of the text console writer: sequencer, datapath and screen store.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath, tcw_screen.
//
//   channel  direction  handshake                 word
//   in       input      i_in_valid / o_in_ready   t_in_word
//   out      output     o_out_valid / i_out_ready t_out_word
//   cfg      input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// An ordinary byte is captured, then committed once the output can take a word; the
// commit updates the cursor, writes the cell and loads the result register.
// A scroll holds off input while the store sweeps its cells, moving one cell per cycle.
// After reset o_in_ready stays low while the store is cleared.
// A stalled output holds one word; the next input word is still captured.
`default_nettype none

module text_console_writer_top #(
    parameter int SCREEN_COLS = tcw_pkg::DEF_COLS,
    parameter int SCREEN_ROWS = tcw_pkg::DEF_ROWS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire tcw_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tcw_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcw_pkg::*;

    localparam int AW = $clog2(SCREEN_COLS * SCREEN_ROWS);

    t_ctl_cmd      cmd;
    t_dp_stat      stat;
    logic          scr_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [7:0]    attr;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .i_scr_busy  (scr_busy),
        .o_cmd       (cmd)
    );

    tcw_datapath #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_word (o_out_word),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_attr     (attr)
    );

    tcw_screen #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_screen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scroll_go (cmd.scroll_go),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_attr      (attr),
        .o_busy      (scr_busy)
    );

endmodule

`default_nettype wire

/* design/tcw_checker.sv */
// Port-level checks of the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top_defines.svh.
`include "text_console_writer_top_defines.svh"
`default_nettype none

module tcw_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tcw_pkg::t_out_word o_out_word
);
    import tcw_pkg::*;

    `TCW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `TCW_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_word))
    `TCW_ASSERT_NOW(a_no_write_zero, o_out_valid && !o_out_word.cell_written,
        o_out_word.cell_addr == '0 && o_out_word.cell_value == '0)
    `TCW_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)
    `TCW_ASSERT_NOW(a_scroll_stalls, $rose(o_out_valid) && o_out_word.scrolled, !o_in_ready)

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
